[hw/rtl/scaled_four_digit_segment_scanner_assert.svh]
// assertion macros for the scanner checker
`ifndef SCALED_FOUR_DIGIT_SEGMENT_SCANNER_ASSERT_SVH
`define SCALED_FOUR_DIGIT_SEGMENT_SCANNER_ASSERT_SVH

// checked outside reset only
`define SFDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define SFDS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/sfds_pkg.sv]
// types, constants and table builders for the segment scanner
`timescale 1ns / 1ps

package sfds_pkg;

  localparam int unsigned DIGITS        = 4;
  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned ENTRY_W       = DIGITS * DIGIT_W;
  localparam int unsigned SAMPLE_LEVELS = 256;
  localparam int unsigned LUT_W         = SAMPLE_LEVELS * ENTRY_W;
  localparam int unsigned ADC_MAX       = 255;
  localparam int unsigned VALUE_MAX     = 9999;

  localparam logic [2:0] PHASE_BLANK = 3'd0;
  localparam logic [2:0] PHASE_LAST  = 3'd4;

  localparam logic [1:0] POS_TENS    = 2'd1;

  localparam logic [7:0] SEG_BLANK   = 8'hFF;
  localparam logic [7:0] DP_MASK     = 8'h7F;
  localparam logic [3:0] ENABLES_OFF = 4'hF;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] segments;
    logic [3:0] digit_enables;
  } out_item_t;

  // index 0 units .. index 3 thousands
  typedef logic [DIGITS-1:0][DIGIT_W-1:0] digits_t;

  typedef struct packed {
    logic sample_we;
    logic tick;
  } ctrl_t;

  // active-low seven-segment code, blank for anything above nine
  function automatic logic [7:0] seg_code(input logic [DIGIT_W-1:0] d);
    logic [7:0] code;
    unique case (d)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

  // scaled decimal digits for every converter code, evaluated at elaboration
  function automatic logic [LUT_W-1:0] build_scale_lut(input int unsigned full_scale);
    logic [LUT_W-1:0] lut;
    int unsigned      y;
    lut = '0;
    for (int unsigned s = 0; s < SAMPLE_LEVELS; s++) begin
      y = (s * full_scale) / ADC_MAX;
      if (y > full_scale) y = full_scale;
      if (y > VALUE_MAX) y = VALUE_MAX;
      lut[s*ENTRY_W +: ENTRY_W] = {4'(y / 1000), 4'((y / 100) % 10),
                                   4'((y / 10) % 10), 4'(y % 10)};
    end
    return lut;
  endfunction

endpackage

[hw/rtl/sfds_digit_store.sv]
// scaled sample lookup and four-digit store
`timescale 1ns / 1ps

module sfds_digit_store
  import sfds_pkg::*;
#(
  parameter int unsigned FULL_SCALE = 1000
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_t      ctrl,
  input  logic [7:0] sample,
  output digits_t    digits
);

  localparam logic [LUT_W-1:0] SCALE_LUT = build_scale_lut(FULL_SCALE);

  digits_t digits_r;
  digits_t digits_nxt;

  always_comb begin
    digits_nxt = digits_r;
    if (ctrl.sample_we) begin
      digits_nxt = digits_t'(SCALE_LUT[{sample, 4'b0000} +: ENTRY_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r <= '0;
    end else begin
      digits_r <= digits_nxt;
    end
  end

  assign digits = digits_r;

endmodule

[hw/rtl/sfds_scan.sv]
// scan phase counter and segment / enable encoder
`timescale 1ns / 1ps

module sfds_scan
  import sfds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_t     ctrl,
  input  digits_t   digits,
  output out_item_t result
);

  logic [2:0] phase_r;
  logic [2:0] phase_nxt;
  logic [7:0] last_seg_r;
  logic [7:0] last_seg_nxt;
  logic [1:0] pos;
  logic [7:0] seg;
  logic [3:0] enables_on;

  always_comb begin
    phase_nxt = (phase_r >= PHASE_LAST) ? PHASE_BLANK : phase_r + 3'd1;
    // phase 1..4 maps to position 0..3
    pos = phase_nxt[1:0] - 2'd1;
    seg = seg_code(digits[pos]);
    if (pos == POS_TENS) begin
      seg = seg & DP_MASK;
    end
    enables_on      = ENABLES_OFF;
    enables_on[pos] = 1'b0;

    if (phase_nxt == PHASE_BLANK) begin
      last_seg_nxt         = last_seg_r;
      result.segments      = last_seg_r;
      result.digit_enables = ENABLES_OFF;
    end else begin
      last_seg_nxt         = seg;
      result.segments      = seg;
      result.digit_enables = enables_on;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PHASE_BLANK;
      last_seg_r <= SEG_BLANK;
    end else if (ctrl.tick) begin
      phase_r    <= phase_nxt;
      last_seg_r <= last_seg_nxt;
    end
  end

endmodule

[hw/rtl/scaled_four_digit_segment_scanner.sv]
// top level of the scaled four-digit seven-segment scanner
`timescale 1ns / 1ps
// throughput: one request per cycle while the result is not stalled, samples and ticks in any mix
// a tick's result sits in the output register in the cycle after acceptance
// a sample gives no result; its digits are seen by a tick in the very next cycle
// the sample lookup is a 256-entry scaling table built at elaboration
// reset: phase 0, digits all zero, last segments all off, output empty

module scaled_four_digit_segment_scanner
  import sfds_pkg::*;
#(
  parameter int unsigned FULL_SCALE = 1000
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctrl_t     ctrl;
  digits_t   digits;
  out_item_t scan_result;

  logic      in_fire;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_data_r;
  out_item_t out_data_nxt;

  // output register parts the two sides: take a request whenever the slot frees
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // decode the request kind into strobes for the store and the scanner
  always_comb begin
    ctrl.sample_we = in_fire && (in_data.op == OP_SAMPLE);
    ctrl.tick      = in_fire && (in_data.op == OP_TICK);
  end

  // sample path: table lookup straight into the digit store
  sfds_digit_store #(
    .FULL_SCALE (FULL_SCALE)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .sample (in_data.sample),
    .digits (digits)
  );

  // tick path: advance phase and encode the selected digit
  sfds_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .digits (digits),
    .result (scan_result)
  );

  // result register, loaded only by ticks
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (ctrl.tick) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = scan_result;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/sfds_checker.sv]
// port-level checks for the segment scanner, bound to the top level
`timescale 1ns / 1ps
`include "scaled_four_digit_segment_scanner_assert.svh"

module sfds_checker
  import sfds_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `SFDS_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result pending after reset")
  `SFDS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "stalled result dropped")
  `SFDS_ASSERT(a_sample_silent, in_valid && in_ready && (in_data.op == OP_SAMPLE) && !out_valid |=> !out_valid, "sample request produced a result")
  `SFDS_ASSERT(a_one_digit, out_valid && (out_data.digit_enables != ENABLES_OFF) |-> $onehot(~out_data.digit_enables), "more than one digit enabled")
  `SFDS_ASSERT(a_tens_point, out_valid && (out_data.digit_enables == 4'b1101) |-> !out_data.segments[7], "decimal point dark on tens digit")

endmodule

bind scaled_four_digit_segment_scanner sfds_checker u_sfds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
